// ===== design/srfr_pkg.sv =====
// ----------------------------------------------------------------------------
// srfr_pkg: shared types and constants of the servo reply frame receiver
// Holds the configuration register codes, frame limits and the result record
// that passes from the frame tracker to the output stage.
// ----------------------------------------------------------------------------
package srfr_pkg;

    // byte and field widths
    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 3;
    localparam int POS_W       = 3;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 8;

    // frame layout
    localparam int SHOWN_PARAMS = 4;
    localparam int MIN_LENGTH   = 3;
    localparam int POS_ID       = 0;
    localparam int POS_LENGTH   = 1;
    localparam int POS_COMMAND  = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_BYTE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH  = 8'd1;

    // configuration reset values
    localparam logic [BYTE_W-1:0] HEADER_RESET     = 8'h55;
    localparam logic [LEN_W-1:0]  MAX_LENGTH_RESET = 3'd7;

    // checksum status codes
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    // packed output beat width: id, command, count, four params, padded to bytes
    localparam int TDATA_BITS = 2 * BYTE_W + LEN_W + SHOWN_PARAMS * BYTE_W;
    localparam int M_TDATA_W  = ((TDATA_BITS + 7) / 8) * 8;

    // configuration seen by the frame tracker
    typedef struct packed {
        logic [BYTE_W-1:0] header_byte;
        logic [LEN_W-1:0]  max_length;
    } cfg_t;

    // one decoded reply frame
    typedef struct packed {
        logic                                 status;
        logic [BYTE_W-1:0]                    servo_id;
        logic [BYTE_W-1:0]                    command;
        logic [LEN_W-1:0]                     param_count;
        logic [SHOWN_PARAMS-1:0][BYTE_W-1:0]  params;
    } result_t;

endpackage

// ===== design/servo_reply_frame_receiver_unit.sv =====
// ----------------------------------------------------------------------------
// servo_reply_frame_receiver_unit: servo reply frame receiver
// Deframes received serial bytes into reply records with checksum status.
// ----------------------------------------------------------------------------
// One received byte is taken per beat, every cycle, with no gaps needed
// between frames. Each byte updates the frame tracker in the cycle it is
// accepted; a frame's record appears on the master side in the cycle after its
// checksum byte is accepted. The single output register sets the rate: the
// slave side stalls only while a record waits on the master side and is not
// being taken in that cycle. Frames with a bad length are dropped without a
// record; a frame with a bad checksum gives a record with tuser set.
// Configuration writes are always accepted and belong in idle periods.
module servo_reply_frame_receiver_unit #(
    parameter int MAX_PARAMS = 4
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // received bytes
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [srfr_pkg::BYTE_W-1:0]         s_tdata,   // rx_byte
    // decoded reply frames
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // servo_id, command, param_count, param0, param1, param2, param3, zero pad
    output logic [srfr_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tuser,   // status
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [srfr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [srfr_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int PAD_W = srfr_pkg::M_TDATA_W - srfr_pkg::TDATA_BITS;

    srfr_pkg::cfg_t    cfg_reg, cfg_next;
    srfr_pkg::result_t result;
    srfr_pkg::result_t out_reg;
    logic              out_valid_reg, out_valid_next;
    logic              byte_accept;
    logic              result_valid;

    // configuration registers
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                srfr_pkg::REG_HEADER_BYTE: cfg_next.header_byte = cfg_data;
                srfr_pkg::REG_MAX_LENGTH:
                    cfg_next.max_length = cfg_data[srfr_pkg::LEN_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.header_byte <= srfr_pkg::HEADER_RESET;
            cfg_reg.max_length  <= srfr_pkg::MAX_LENGTH_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_ready = 1'b1;

    // input handshake: take a byte unless a record is stuck at the output
    assign s_tready    = !out_valid_reg || m_tready;
    assign byte_accept = s_tvalid && s_tready;

    srfr_frame_tracker #(
        .MAX_PARAMS (MAX_PARAMS)
    ) u_tracker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .byte_accept  (byte_accept),
        .rx_byte      (s_tdata),
        .cfg          (cfg_reg),
        .result_valid (result_valid),
        .result       (result)
    );

    // output register
    always_comb begin
        out_valid_next = out_valid_reg;
        if (byte_accept) begin
            out_valid_next = result_valid;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (result_valid) begin
            out_reg <= result;
        end
    end

    // master side packing, first field lowest
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {{PAD_W{1'b0}},
                       out_reg.params[3], out_reg.params[2],
                       out_reg.params[1], out_reg.params[0],
                       out_reg.param_count, out_reg.command, out_reg.servo_id};

    // a new record only follows an accepted byte
    a_record_from_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(byte_accept && result_valid))
        else $error("record appeared without a checksum beat");

    // absent parameters read as zero
    a_absent_params_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_reg.param_count == '0) |->
        (out_reg.params[0] == '0 && out_reg.params[1] == '0 &&
         out_reg.params[2] == '0 && out_reg.params[3] == '0))
        else $error("parameter shown beyond the frame's count");

    // the parameter count never exceeds the shown slots
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> out_reg.param_count <= srfr_pkg::LEN_W'(srfr_pkg::SHOWN_PARAMS))
        else $error("parameter count out of range");

endmodule

// ===== design/srfr_frame_tracker.sv =====
// ----------------------------------------------------------------------------
// srfr_frame_tracker: byte-wise frame state of the servo reply receiver
// Hunts for the double header, collects id, length, command and parameters,
// keeps the running checksum and flags a decoded frame on its checksum byte.
// ----------------------------------------------------------------------------
module srfr_frame_tracker #(
    parameter int MAX_PARAMS = 4
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       byte_accept,
    input  logic [srfr_pkg::BYTE_W-1:0] rx_byte,
    input  srfr_pkg::cfg_t             cfg,
    output logic                       result_valid,
    output srfr_pkg::result_t          result
);

    // parameter slots that a frame can ever fill
    localparam int HELD = (MAX_PARAMS < srfr_pkg::SHOWN_PARAMS) ?
                          MAX_PARAMS : srfr_pkg::SHOWN_PARAMS;
    // largest length field that still fits the parameter store
    localparam logic [srfr_pkg::BYTE_W-1:0] LEN_LIMIT =
        srfr_pkg::BYTE_W'(MAX_PARAMS + srfr_pkg::MIN_LENGTH);
    localparam logic [srfr_pkg::BYTE_W-1:0] LEN_MIN =
        srfr_pkg::BYTE_W'(srfr_pkg::MIN_LENGTH);
    localparam logic [srfr_pkg::POS_W-1:0] P_ID      = srfr_pkg::POS_W'(srfr_pkg::POS_ID);
    localparam logic [srfr_pkg::POS_W-1:0] P_LENGTH  = srfr_pkg::POS_W'(srfr_pkg::POS_LENGTH);
    localparam logic [srfr_pkg::POS_W-1:0] P_COMMAND = srfr_pkg::POS_W'(srfr_pkg::POS_COMMAND);

    logic                          in_frame_reg, in_frame_next;
    logic                          header_seen_reg, header_seen_next;
    logic [srfr_pkg::POS_W-1:0]    pos_reg, pos_next;
    logic [srfr_pkg::LEN_W-1:0]    frame_length_reg, frame_length_next;
    logic [srfr_pkg::BYTE_W-1:0]   sum_reg, sum_next;
    logic [srfr_pkg::BYTE_W-1:0]   id_reg, id_next;
    logic [srfr_pkg::BYTE_W-1:0]   command_reg, command_next;
    logic [srfr_pkg::BYTE_W-1:0]   held_reg [HELD];

    logic                          is_header;
    logic                          length_bad;
    logic                          in_body;
    logic                          at_checksum;
    logic [srfr_pkg::LEN_W-1:0]    count;
    logic [srfr_pkg::BYTE_W-1:0]   shown [srfr_pkg::SHOWN_PARAMS];

    // byte classification
    assign is_header   = (rx_byte == cfg.header_byte);
    assign length_bad  = (rx_byte < LEN_MIN) ||
                         (rx_byte > {{(srfr_pkg::BYTE_W - srfr_pkg::LEN_W){1'b0}},
                                     cfg.max_length}) ||
                         (rx_byte > LEN_LIMIT);
    assign in_body     = (pos_reg < frame_length_reg);
    assign at_checksum = in_frame_reg && (pos_reg > P_LENGTH) && !in_body;
    assign count       = frame_length_reg - srfr_pkg::LEN_W'(srfr_pkg::MIN_LENGTH);

    // next frame state for an accepted byte
    always_comb begin
        in_frame_next     = in_frame_reg;
        header_seen_next  = header_seen_reg;
        pos_next          = pos_reg;
        frame_length_next = frame_length_reg;
        sum_next          = sum_reg;
        id_next           = id_reg;
        command_next      = command_reg;
        if (!in_frame_reg) begin
            // hunting for two header bytes in a row
            if (is_header && header_seen_reg) begin
                in_frame_next    = 1'b1;
                header_seen_next = 1'b0;
                pos_next         = P_ID;
                sum_next         = '0;
            end else begin
                header_seen_next = is_header;
            end
        end else if (pos_reg == P_ID) begin
            id_next  = rx_byte;
            sum_next = sum_reg + rx_byte;
            pos_next = P_LENGTH;
        end else if (pos_reg == P_LENGTH) begin
            if (length_bad) begin
                // abandon silently, length byte is not a header candidate
                in_frame_next    = 1'b0;
                header_seen_next = 1'b0;
                pos_next         = '0;
            end else begin
                frame_length_next = rx_byte[srfr_pkg::LEN_W-1:0];
                sum_next          = sum_reg + rx_byte;
                pos_next          = P_COMMAND;
            end
        end else if (in_body) begin
            if (pos_reg == P_COMMAND) begin
                command_next = rx_byte;
            end
            sum_next = sum_reg + rx_byte;
            pos_next = pos_reg + srfr_pkg::POS_W'(1);
        end else begin
            // checksum byte closes the frame
            in_frame_next    = 1'b0;
            header_seen_next = 1'b0;
            pos_next         = '0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg    <= 1'b0;
            header_seen_reg <= 1'b0;
            pos_reg         <= '0;
        end else if (byte_accept) begin
            in_frame_reg    <= in_frame_next;
            header_seen_reg <= header_seen_next;
            pos_reg         <= pos_next;
        end
    end

    // frame payload
    always_ff @(posedge aclk) begin
        if (byte_accept) begin
            frame_length_reg <= frame_length_next;
            sum_reg          <= sum_next;
            id_reg           <= id_next;
            command_reg      <= command_next;
        end
    end

    // parameter slots, each written at its own byte position
    for (genvar i = 0; i < HELD; i++) begin : g_held
        always_ff @(posedge aclk) begin
            if (byte_accept && in_frame_reg && in_body &&
                pos_reg == srfr_pkg::POS_W'(i + srfr_pkg::MIN_LENGTH)) begin
                held_reg[i] <= rx_byte;
            end
        end
    end

    // shown parameters, zero past the frame's count
    for (genvar k = 0; k < srfr_pkg::SHOWN_PARAMS; k++) begin : g_shown
        if (k < HELD) begin : g_live
            assign shown[k] = (srfr_pkg::LEN_W'(k) < count) ? held_reg[k] : '0;
        end else begin : g_none
            assign shown[k] = '0;
        end
    end

    // decoded frame
    always_comb begin
        result.status      = ((~sum_reg) == rx_byte) ? srfr_pkg::STATUS_OK
                                                     : srfr_pkg::STATUS_BAD;
        result.servo_id    = id_reg;
        result.command     = command_reg;
        result.param_count = count;
        for (int k = 0; k < srfr_pkg::SHOWN_PARAMS; k++) begin
            result.params[k] = shown[k];
        end
    end

    assign result_valid = byte_accept && at_checksum;

    // checks on the frame state
    a_hunt_pos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_frame_reg |-> pos_reg == '0)
        else $error("position left nonzero while hunting");

    a_no_header_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        in_frame_reg |-> !header_seen_reg)
        else $error("header flag set inside a frame");

    a_length_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_frame_reg && pos_reg > P_LENGTH) |->
        (frame_length_reg >= srfr_pkg::LEN_W'(srfr_pkg::MIN_LENGTH) &&
         pos_reg <= frame_length_reg))
        else $error("frame length or position out of range");

endmodule
